[src/wwf_pkg.sv]
// ----------------------------------------------------------------------------
// wwf_pkg
// Shared types and constants of the LFO-swept low-pass biquad (wah-wah).
// ----------------------------------------------------------------------------
package wwf_pkg;

  localparam int TABLE_BITS      = 12;
  localparam int TABLE_ENTRIES   = (1 << TABLE_BITS) + 1;
  localparam int ADDR_W          = TABLE_BITS + 1;
  localparam int UPDATE_INTERVAL = 30;
  localparam int CNT_W           = $clog2(UPDATE_INTERVAL + 1);
  localparam int FRAC_W          = 16;
  localparam int COEF_W          = 32;
  localparam int ENTRY_W         = 3 * COEF_W;
  localparam int RES_W           = 29;

  // configuration register indexes
  localparam logic CFG_LFO_STEP  = 1'b0;
  localparam logic CFG_LFO_START = 1'b1;

  // input command codes
  localparam logic CMD_FRAME = 1'b0;
  localparam logic CMD_TABLE = 1'b1;

  typedef struct packed {
    logic               cmd;
    logic signed [15:0] left_in;
    logic signed [15:0] right_in;
    logic [12:0]        table_index;
    logic signed [31:0] entry_b0;
    logic signed [31:0] entry_a1;
    logic signed [31:0] entry_a2;
  } in_t;

  typedef struct packed {
    logic signed [15:0] left_out;
    logic signed [15:0] right_out;
  } out_t;

  typedef enum logic [3:0] {
    S_IDLE, S_PHASE, S_ADDR, S_RD0, S_RD1, S_RD2, S_IMUL, S_IACC,
    S_FSUM, S_FM0, S_FM1, S_FM2, S_FM3, S_FY, S_FO, S_DONE
  } state_t;

  typedef enum logic [3:0] {
    DP_NONE, DP_PHASE, DP_ADDR, DP_RD0, DP_RD1, DP_RD2, DP_IMUL, DP_IACC,
    DP_FSUM, DP_FM0, DP_FM1, DP_FM2, DP_FM3, DP_FY, DP_FO, DP_LOAD
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [1:0] k;       // coefficient being interpolated: b0, a1, a2
    logic       ch;      // 0 = left, 1 = right
    logic       accept;  // input transaction this cycle
  } dp_cmd_t;

  typedef struct packed {
    logic refresh;       // update counter at zero
  } dp_sts_t;

endpackage

[src/wwf_ram.sv]
// ----------------------------------------------------------------------------
// wwf_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module wwf_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 4097
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/wwf_ctrl.sv]
// ----------------------------------------------------------------------------
// wwf_ctrl
// Sequencer: walks the datapath through phase update, coefficient refresh
// and the two channel filters, and owns both handshakes.
// ----------------------------------------------------------------------------
module wwf_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_cmd,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  wwf_pkg::dp_sts_t sts,
  output wwf_pkg::dp_cmd_t cmd
);

  wwf_pkg::state_t state_r, state_nxt;
  logic [1:0]      k_r, k_nxt;
  logic            ch_r, ch_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            can_load;

  assign can_load = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    ch_nxt    = ch_r;
    case (state_r)
      wwf_pkg::S_IDLE: begin
        if (in_valid && in_cmd == wwf_pkg::CMD_FRAME) state_nxt = wwf_pkg::S_PHASE;
      end
      wwf_pkg::S_PHASE: state_nxt = wwf_pkg::S_ADDR;
      wwf_pkg::S_ADDR: begin
        ch_nxt = 1'b0;
        k_nxt  = 2'd0;
        state_nxt = sts.refresh ? wwf_pkg::S_RD0 : wwf_pkg::S_FSUM;
      end
      wwf_pkg::S_RD0:  state_nxt = wwf_pkg::S_RD1;
      wwf_pkg::S_RD1:  state_nxt = wwf_pkg::S_RD2;
      wwf_pkg::S_RD2:  state_nxt = wwf_pkg::S_IMUL;
      wwf_pkg::S_IMUL: state_nxt = wwf_pkg::S_IACC;
      wwf_pkg::S_IACC: begin
        if (k_r == 2'd2) begin
          state_nxt = wwf_pkg::S_FSUM;
        end else begin
          k_nxt     = k_r + 2'd1;
          state_nxt = wwf_pkg::S_IMUL;
        end
      end
      wwf_pkg::S_FSUM: state_nxt = wwf_pkg::S_FM0;
      wwf_pkg::S_FM0:  state_nxt = wwf_pkg::S_FM1;
      wwf_pkg::S_FM1:  state_nxt = wwf_pkg::S_FM2;
      wwf_pkg::S_FM2:  state_nxt = wwf_pkg::S_FM3;
      wwf_pkg::S_FM3:  state_nxt = wwf_pkg::S_FY;
      wwf_pkg::S_FY:   state_nxt = wwf_pkg::S_FO;
      wwf_pkg::S_FO: begin
        if (ch_r) begin
          state_nxt = wwf_pkg::S_DONE;
        end else begin
          ch_nxt    = 1'b1;
          state_nxt = wwf_pkg::S_FSUM;
        end
      end
      wwf_pkg::S_DONE: begin
        if (can_load) state_nxt = wwf_pkg::S_IDLE;
      end
      default: state_nxt = wwf_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    cmd.op        = wwf_pkg::DP_NONE;
    cmd.k         = k_r;
    cmd.ch        = ch_r;
    out_valid_nxt = out_ready ? 1'b0 : out_valid_r;
    case (state_r)
      wwf_pkg::S_IDLE:  in_ready = 1'b1;
      wwf_pkg::S_PHASE: cmd.op = wwf_pkg::DP_PHASE;
      wwf_pkg::S_ADDR:  cmd.op = wwf_pkg::DP_ADDR;
      wwf_pkg::S_RD0:   cmd.op = wwf_pkg::DP_RD0;
      wwf_pkg::S_RD1:   cmd.op = wwf_pkg::DP_RD1;
      wwf_pkg::S_RD2:   cmd.op = wwf_pkg::DP_RD2;
      wwf_pkg::S_IMUL:  cmd.op = wwf_pkg::DP_IMUL;
      wwf_pkg::S_IACC:  cmd.op = wwf_pkg::DP_IACC;
      wwf_pkg::S_FSUM:  cmd.op = wwf_pkg::DP_FSUM;
      wwf_pkg::S_FM0:   cmd.op = wwf_pkg::DP_FM0;
      wwf_pkg::S_FM1:   cmd.op = wwf_pkg::DP_FM1;
      wwf_pkg::S_FM2:   cmd.op = wwf_pkg::DP_FM2;
      wwf_pkg::S_FM3:   cmd.op = wwf_pkg::DP_FM3;
      wwf_pkg::S_FY:    cmd.op = wwf_pkg::DP_FY;
      wwf_pkg::S_FO:    cmd.op = wwf_pkg::DP_FO;
      wwf_pkg::S_DONE: begin
        if (can_load) begin
          cmd.op        = wwf_pkg::DP_LOAD;
          out_valid_nxt = 1'b1;
        end
      end
      default: cmd.op = wwf_pkg::DP_NONE;
    endcase
    cmd.accept = in_ready && in_valid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= wwf_pkg::S_IDLE;
      k_r         <= 2'd0;
      ch_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      ch_r        <= ch_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

[src/wwf_datapath.sv]
// ----------------------------------------------------------------------------
// wwf_datapath
// LFO phase, coefficient table and interpolation, two biquad channels, all
// sharing one 33x33 multiplier with a product register.
// ----------------------------------------------------------------------------
module wwf_datapath (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [63:0]      cfg_wdata,
  input  wwf_pkg::in_t     in_data,
  input  wwf_pkg::dp_cmd_t cmd,
  output wwf_pkg::dp_sts_t sts,
  output wwf_pkg::out_t    out_data
);

  logic [63:0] step_r, start_r, phase_r, ph_r;
  logic [wwf_pkg::CNT_W-1:0] cnt_r;
  logic [2:0][31:0] active_r, c0_r, c1_r;
  logic signed [15:0] xl_r, xr_r;
  logic signed [15:0] x1_r [2];
  logic signed [15:0] x2_r [2];
  logic signed [31:0] y1_r [2];
  logic signed [31:0] y2_r [2];
  logic [wwf_pkg::RES_W-1:0] res_r [2];
  logic signed [17:0] sum_r;
  logic signed [63:0] p_r, acc_r;
  logic signed [15:0] chout_r [2];
  wwf_pkg::out_t out_r;

  // table
  logic                       ram_we;
  logic [wwf_pkg::ADDR_W-1:0] raddr, i0;
  logic [wwf_pkg::ENTRY_W-1:0] rdata;
  logic [wwf_pkg::FRAC_W-1:0] frac;

  assign ram_we = cmd.accept && in_data.cmd == wwf_pkg::CMD_TABLE &&
                  in_data.table_index <= 13'(wwf_pkg::TABLE_ENTRIES - 1);
  assign i0     = {1'b0, ph_r[63 -: wwf_pkg::TABLE_BITS]};
  assign frac   = ph_r[63 - wwf_pkg::TABLE_BITS -: wwf_pkg::FRAC_W];
  assign raddr  = (cmd.op == wwf_pkg::DP_RD0) ? i0 : i0 + 1'b1;

  wwf_ram #(.WIDTH(wwf_pkg::ENTRY_W), .DEPTH(wwf_pkg::TABLE_ENTRIES)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (in_data.table_index[wwf_pkg::ADDR_W-1:0]),
    .wdata ({in_data.entry_a2, in_data.entry_a1, in_data.entry_b0}),
    .raddr (raddr),
    .rdata (rdata)
  );

  // shared multiplier
  logic signed [31:0] c0_k, c1_k, x_cur;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;

  assign c0_k  = c0_r[cmd.k];
  assign c1_k  = c1_r[cmd.k];
  assign x_cur = cmd.ch ? 32'(xr_r) : 32'(xl_r);

  always_comb begin
    case (cmd.op)
      wwf_pkg::DP_IMUL: begin
        mul_a = {c1_k[31], c1_k} - {c0_k[31], c0_k};
        mul_b = {17'd0, frac};
      end
      wwf_pkg::DP_FM0: begin
        mul_a = 33'(signed'(active_r[0]));
        mul_b = 33'(sum_r);
      end
      wwf_pkg::DP_FM1: begin
        mul_a = 33'(signed'(active_r[1]));
        mul_b = 33'(y1_r[cmd.ch]);
      end
      wwf_pkg::DP_FM2: begin
        mul_a = 33'(signed'(active_r[2]));
        mul_b = 33'(y2_r[cmd.ch]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // symmetric rounding: bias by half, one less when negative
  logic signed [63:0] rnd16, rs16;
  assign rnd16 = p_r + (p_r[63] ? 64'sh7FFF : 64'sh8000);
  assign rs16  = rnd16 >>> 16;

  logic signed [34:0] yf;
  logic signed [31:0] yc;
  assign yf = acc_r[63:29];
  always_comb begin
    if (yf > 35'sh0_4000_0000)       yc = 32'sh4000_0000;
    else if (yf < -35'sh0_4000_0000) yc = 32'shC000_0000;
    else                             yc = yf[31:0];
  end

  logic signed [31:0] yo, rnd10;
  logic signed [21:0] r10;
  logic signed [15:0] sat;
  assign yo    = y1_r[cmd.ch];
  assign rnd10 = yo + (yo[31] ? 32'sh1FF : 32'sh200);
  assign r10   = 22'(rnd10 >>> 10);
  always_comb begin
    if (r10 > 22'sd32767)       sat = 16'sh7FFF;
    else if (r10 < -22'sd32768) sat = 16'sh8000;
    else                        sat = r10[15:0];
  end

  // architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r   <= '0;
      start_r  <= '0;
      phase_r  <= '0;
      cnt_r    <= '0;
      active_r <= '0;
      for (int c = 0; c < 2; c++) begin
        x1_r[c]  <= '0;
        x2_r[c]  <= '0;
        y1_r[c]  <= '0;
        y2_r[c]  <= '0;
        res_r[c] <= '0;
      end
    end else begin
      if (cfg_we) begin
        if (cfg_index == wwf_pkg::CFG_LFO_STEP) step_r <= cfg_wdata;
        else                                    start_r <= cfg_wdata;
      end
      case (cmd.op)
        wwf_pkg::DP_PHASE: phase_r <= phase_r + step_r;
        wwf_pkg::DP_ADDR: begin
          cnt_r <= (cnt_r == wwf_pkg::CNT_W'(wwf_pkg::UPDATE_INTERVAL - 1)) ?
                   '0 : cnt_r + 1'b1;
        end
        wwf_pkg::DP_IACC: active_r[cmd.k] <= c0_k + rs16[31:0];
        wwf_pkg::DP_FY: begin
          x2_r[cmd.ch]  <= x1_r[cmd.ch];
          x1_r[cmd.ch]  <= x_cur[15:0];
          y2_r[cmd.ch]  <= y1_r[cmd.ch];
          y1_r[cmd.ch]  <= yc;
          res_r[cmd.ch] <= acc_r[wwf_pkg::RES_W-1:0];
        end
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.accept && in_data.cmd == wwf_pkg::CMD_FRAME) begin
      xl_r <= in_data.left_in;
      xr_r <= in_data.right_in;
    end
    case (cmd.op)
      wwf_pkg::DP_ADDR: ph_r <= phase_r + start_r;
      wwf_pkg::DP_RD1:  c0_r <= rdata;
      wwf_pkg::DP_RD2:  c1_r <= rdata;
      wwf_pkg::DP_IMUL: p_r  <= mul_p[63:0];
      wwf_pkg::DP_FSUM: begin
        sum_r <= 18'(x_cur) + (18'(x1_r[cmd.ch]) <<< 1) + 18'(x2_r[cmd.ch]);
      end
      wwf_pkg::DP_FM0: p_r <= mul_p[63:0];
      wwf_pkg::DP_FM1: begin
        acc_r <= (p_r <<< 10) + 64'(res_r[cmd.ch]);
        p_r   <= mul_p[63:0];
      end
      wwf_pkg::DP_FM2: begin
        acc_r <= acc_r - p_r;
        p_r   <= mul_p[63:0];
      end
      wwf_pkg::DP_FM3:  acc_r <= acc_r - p_r;
      wwf_pkg::DP_FO:   chout_r[cmd.ch] <= sat;
      wwf_pkg::DP_LOAD: begin
        out_r.left_out  <= chout_r[0];
        out_r.right_out <= chout_r[1];
      end
      default: ;
    endcase
  end

  assign sts.refresh = (cnt_r == '0);
  assign out_data    = out_r;

endmodule

[src/wah_wah_filter_fixed.sv]
// ----------------------------------------------------------------------------
// wah_wah_filter_fixed
// Stereo wah-wah: Q10 low-pass biquad swept by an interpolated coefficient
// table under a 64-bit LFO phase.
//
// Input channel (in_valid/in_ready/in_data): a table write (cmd = 1) stores
// one Q29 entry, yields no result and does not stall the input. A frame
// (cmd = 0) yields one result on out_valid/out_ready/out_data. A
// coefficient refresh frame (first frame after reset, then every 30th) also
// reads the table and interpolates. The pace is set by the single shared
// multiplier (three products per channel, three for the interpolation) and
// by two table reads on one read port. in_ready is high only while the
// sequencer is idle, so a new frame is taken only once the last is through.
// Configuration: cfg_we with cfg_index 0 (phase step) or 1 (phase offset);
// the user must write it only while idle; the block does not enforce this.
// Reset (rst_n low, synchronous) clears phase, counter, active
// coefficients and filter state; the table is unknown until written. A
// stalled receiver holds the result in the output register; the next frame
// may be computed meanwhile and waits at the end.
// ----------------------------------------------------------------------------
module wah_wah_filter_fixed (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic          cfg_index,
  input  logic [63:0]   cfg_wdata,
  input  logic          in_valid,
  output logic          in_ready,
  input  wwf_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output wwf_pkg::out_t out_data
);

  wwf_pkg::dp_cmd_t cmd;
  wwf_pkg::dp_sts_t sts;

  wwf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_cmd    (in_data.cmd),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  wwf_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_data)
  );

  a_frame_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.cmd == wwf_pkg::CMD_FRAME |=> !in_ready)
    else $error("frame transaction did not start processing");

  a_table_quick: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.cmd == wwf_pkg::CMD_TABLE |=> in_ready)
    else $error("table write stalled the input");

  a_out_from_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(cmd.op == wwf_pkg::DP_LOAD))
    else $error("result shown without a load");

endmodule
